### hw/rtl/nus_pkg.sv
// ----------------------------------------------------------------------------
// nus_pkg: shared constants, types and tables
// Frame geometry, scaling reciprocals, color conversion constants and the
// structs that travel between the scaler's pipeline parts.
// ----------------------------------------------------------------------------
package nus_pkg;

   // Frame geometry
   localparam int SRC_W = 320;
   localparam int SRC_H = 200;
   localparam int DST_W = 800;
   localparam int DST_H = 480;

   // Field widths of the request and response channels
   localparam int SRC_COL_W = 9;
   localparam int SRC_ROW_W = 8;
   localparam int OUT_COL_W = 10;
   localparam int OUT_ROW_W = 9;
   localparam int PIX_W     = 16;

   // Frame store
   localparam int FRAME_DEPTH = SRC_W * SRC_H;
   localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

   // Source coordinate widths (hold up to the frame size itself)
   localparam int SX_W = $clog2(SRC_W + 1);
   localparam int SY_W = $clog2(SRC_H + 1);

   // Column map: sx = (dx*SRC_W)/DST_W as multiply by ceil(2^K/DST_W), shift K.
   // K = numerator bits + clog2(divisor) keeps the quotient exact.
   localparam int PCOL_W  = OUT_COL_W + SX_W;
   localparam int KCOL    = PCOL_W + $clog2(DST_W);
   localparam int MCOL_W  = PCOL_W + 2;
   localparam longint unsigned MCOL_L =
      ((64'd1 << KCOL) + 64'(DST_W) - 64'd1) / 64'(DST_W);
   localparam logic [MCOL_W-1:0] MCOL = MCOL_W'(MCOL_L);
   localparam int PRODC_W = PCOL_W + MCOL_W;

   // Row map, same scheme
   localparam int PROW_W  = OUT_ROW_W + SY_W;
   localparam int KROW    = PROW_W + $clog2(DST_H);
   localparam int MROW_W  = PROW_W + 2;
   localparam longint unsigned MROW_L =
      ((64'd1 << KROW) + 64'(DST_H) - 64'd1) / 64'(DST_H);
   localparam logic [MROW_W-1:0] MROW = MROW_W'(MROW_L);
   localparam int PRODR_W = PROW_W + MROW_W;

   // Color conversion constants
   localparam int C5_MAX     = 31;
   localparam int C6_MAX     = 63;
   localparam int C8_MAX     = 255;
   localparam int Y_R        = 299;
   localparam int Y_G        = 587;
   localparam int Y_B        = 114;
   localparam int U_K        = 565;
   localparam int V_K        = 713;
   localparam int YUV_DIV    = 1000;
   localparam int CHROMA_OFS = 128;

   // Division by YUV_DIV: numerators stay below 2^18 (255*1000 max)
   localparam int YSUM_W  = 18;
   localparam int DIV_K   = YSUM_W + $clog2(YUV_DIV);
   localparam int DIV_M_W = YSUM_W + 2;
   localparam logic [DIV_M_W-1:0] DIV_M =
      DIV_M_W'(((64'd1 << DIV_K) + 64'(YUV_DIV) - 64'd1) / 64'(YUV_DIV));
   localparam int DIVP_W  = YSUM_W + DIV_M_W;

   // Result queue
   localparam int Q_DEPTH = 16;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Request kinds
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   // One frame store access per cycle
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } mem_cmd_type;

   // Result queue status
   typedef struct packed {
      logic               can_take;
      logic [Q_CNT_W-1:0] owed;
      logic [Q_CNT_W-1:0] fill;
   } q_stat_type;

   // Channel expansion tables: c*255/max, floored
   typedef logic [7:0] exp5_tbl_type [32];
   typedef logic [7:0] exp6_tbl_type [64];

   function automatic exp5_tbl_type build_exp5();
      exp5_tbl_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * C8_MAX) / C5_MAX);
      end
      return t;
   endfunction

   function automatic exp6_tbl_type build_exp6();
      exp6_tbl_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * C8_MAX) / C6_MAX);
      end
      return t;
   endfunction

   localparam exp5_tbl_type EXP5_TBL = build_exp5();
   localparam exp6_tbl_type EXP6_TBL = build_exp6();

endpackage

### hw/rtl/nus_if.sv
// ----------------------------------------------------------------------------
// nus_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface nus_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [nus_pkg::SRC_COL_W-1:0]  src_col;
   logic [nus_pkg::SRC_ROW_W-1:0]  src_row;
   logic [nus_pkg::PIX_W-1:0]      src_pixel;
   logic [nus_pkg::OUT_COL_W-1:0]  out_col;
   logic [nus_pkg::OUT_ROW_W-1:0]  out_row;

   modport source (
      output valid, req_type, src_col, src_row, src_pixel, out_col, out_row,
      input  ready
   );
   modport sink (
      input  valid, req_type, src_col, src_row, src_pixel, out_col, out_row,
      output ready
   );
endinterface

interface nus_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nus_pkg::PIX_W-1:0] yuv_pixel;

   modport source (output valid, yuv_pixel, input ready);
   modport sink (input valid, yuv_pixel, output ready);
endinterface

### hw/rtl/nus_addr.sv
// ----------------------------------------------------------------------------
// nus_addr: address pipeline
// Three stages that turn a request into one frame store access: write
// address and range check, nearest-neighbor column/row map, final address.
// ----------------------------------------------------------------------------
module nus_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_type,
   input  logic [nus_pkg::SRC_COL_W-1:0] src_col,
   input  logic [nus_pkg::SRC_ROW_W-1:0] src_row,
   input  logic [nus_pkg::PIX_W-1:0]     src_pixel,
   input  logic [nus_pkg::OUT_COL_W-1:0] out_col,
   input  logic [nus_pkg::OUT_ROW_W-1:0] out_row,
   output nus_pkg::mem_cmd_type          mem_cmd
);

   // Stage A registers
   logic                          a_vld_ff,   a_vld_in;
   logic                          a_rd_ff,    a_rd_in;
   logic                          a_wr_ff,    a_wr_in;
   logic [nus_pkg::ADDR_W-1:0]    a_waddr_ff, a_waddr_in;
   logic [nus_pkg::PIX_W-1:0]     a_wdata_ff, a_wdata_in;
   logic [nus_pkg::PCOL_W-1:0]    a_pcol_ff,  a_pcol_in;
   logic [nus_pkg::PROW_W-1:0]    a_prow_ff,  a_prow_in;

   // Stage B registers
   logic                          b_vld_ff,   b_vld_in;
   logic                          b_rd_ff,    b_rd_in;
   logic                          b_wr_ff,    b_wr_in;
   logic [nus_pkg::ADDR_W-1:0]    b_waddr_ff, b_waddr_in;
   logic [nus_pkg::PIX_W-1:0]     b_wdata_ff, b_wdata_in;
   logic [nus_pkg::PCOL_W-1:0]    b_qcol_ff,  b_qcol_in;
   logic [nus_pkg::PROW_W-1:0]    b_qrow_ff,  b_qrow_in;

   // Stage C: the memory command
   nus_pkg::mem_cmd_type          mem_cmd_ff, mem_cmd_in;

   logic [nus_pkg::PRODC_W-1:0]   col_prod;
   logic [nus_pkg::PRODR_W-1:0]   row_prod;
   logic [nus_pkg::SX_W-1:0]      sx;
   logic [nus_pkg::SY_W-1:0]      sy;
   logic [nus_pkg::ADDR_W-1:0]    rd_addr;
   logic                          in_frame;

   // Stage A: write address, range check, scale products
   always_comb begin
      in_frame   = (32'(src_col) < 32'(nus_pkg::SRC_W)) &&
                   (32'(src_row) < 32'(nus_pkg::SRC_H));
      a_vld_in   = accept;
      a_rd_in    = (req_type == nus_pkg::REQ_READ);
      a_wr_in    = (req_type == nus_pkg::REQ_WRITE) && in_frame;
      a_waddr_in = nus_pkg::ADDR_W'(src_row) * nus_pkg::ADDR_W'(nus_pkg::SRC_W)
                   + nus_pkg::ADDR_W'(src_col);
      a_wdata_in = src_pixel;
      a_pcol_in  = nus_pkg::PCOL_W'(out_col) * nus_pkg::PCOL_W'(nus_pkg::SRC_W);
      a_prow_in  = nus_pkg::PROW_W'(out_row) * nus_pkg::PROW_W'(nus_pkg::SRC_H);
   end

   // Stage B: divide by the destination size via reciprocal multiply
   always_comb begin
      col_prod   = nus_pkg::PRODC_W'(a_pcol_ff) * nus_pkg::PRODC_W'(nus_pkg::MCOL);
      row_prod   = nus_pkg::PRODR_W'(a_prow_ff) * nus_pkg::PRODR_W'(nus_pkg::MROW);
      b_vld_in   = a_vld_ff;
      b_rd_in    = a_rd_ff;
      b_wr_in    = a_wr_ff;
      b_waddr_in = a_waddr_ff;
      b_wdata_in = a_wdata_ff;
      b_qcol_in  = nus_pkg::PCOL_W'(col_prod >> nus_pkg::KCOL);
      b_qrow_in  = nus_pkg::PROW_W'(row_prod >> nus_pkg::KROW);
   end

   // Stage C: saturate to the frame edge, form the read address
   always_comb begin
      if (32'(b_qcol_ff) > 32'(nus_pkg::SRC_W - 1)) begin
         sx = nus_pkg::SX_W'(nus_pkg::SRC_W - 1);
      end else begin
         sx = nus_pkg::SX_W'(b_qcol_ff);
      end
      if (32'(b_qrow_ff) > 32'(nus_pkg::SRC_H - 1)) begin
         sy = nus_pkg::SY_W'(nus_pkg::SRC_H - 1);
      end else begin
         sy = nus_pkg::SY_W'(b_qrow_ff);
      end
      rd_addr = nus_pkg::ADDR_W'(sy) * nus_pkg::ADDR_W'(nus_pkg::SRC_W)
                + nus_pkg::ADDR_W'(sx);
      mem_cmd_in.rd   = b_vld_ff && b_rd_ff;
      mem_cmd_in.wr   = b_vld_ff && b_wr_ff;
      mem_cmd_in.addr = b_rd_ff ? rd_addr : b_waddr_ff;
      mem_cmd_in.data = b_wdata_ff;
   end

   // Control state and memory command; reset clears only the strobes
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         mem_cmd_ff.rd <= 1'b0;
         mem_cmd_ff.wr <= 1'b0;
      end else begin
         a_vld_ff      <= a_vld_in;
         b_vld_ff      <= b_vld_in;
         mem_cmd_ff    <= mem_cmd_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      a_rd_ff         <= a_rd_in;
      a_wr_ff         <= a_wr_in;
      a_waddr_ff      <= a_waddr_in;
      a_wdata_ff      <= a_wdata_in;
      a_pcol_ff       <= a_pcol_in;
      a_prow_ff       <= a_prow_in;
      b_rd_ff         <= b_rd_in;
      b_wr_ff         <= b_wr_in;
      b_waddr_ff      <= b_waddr_in;
      b_wdata_ff      <= b_wdata_in;
      b_qcol_ff       <= b_qcol_in;
      b_qrow_ff       <= b_qrow_in;
   end

   assign mem_cmd = mem_cmd_ff;

endmodule

### hw/rtl/nus_frame.sv
// ----------------------------------------------------------------------------
// nus_frame: source frame store
// Single-port synchronous memory, one access per cycle, registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module nus_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  nus_pkg::mem_cmd_type      mem_cmd,
   output logic                      rd_vld,
   output logic [nus_pkg::PIX_W-1:0] rd_data
);

   logic [nus_pkg::PIX_W-1:0] mem [nus_pkg::FRAME_DEPTH];
   logic [nus_pkg::PIX_W-1:0] rd_data_ff;
   logic                      rd_vld_ff, rd_vld_in;

   // Memory array: write or read, never both
   always_ff @(posedge clock) begin
      if (mem_cmd.wr) begin
         mem[mem_cmd.addr] <= mem_cmd.data;
      end else if (mem_cmd.rd) begin
         rd_data_ff <= mem[mem_cmd.addr];
      end
   end

   // Read data valid flag
   assign rd_vld_in = mem_cmd.rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
   end

   assign rd_vld  = rd_vld_ff;
   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/nus_cvt.sv
// ----------------------------------------------------------------------------
// nus_cvt: RGB565 to packed YUV converter
// Four stages: channel expand and luma sum, luma divide, chroma products,
// chroma divide with offset, clamp and pack.
// ----------------------------------------------------------------------------
module nus_cvt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  logic [nus_pkg::PIX_W-1:0] in_pixel,
   output logic                      out_vld,
   output logic [nus_pkg::PIX_W-1:0] out_pixel
);

   // Stage 1
   logic                          e1_vld_ff,  e1_vld_in;
   logic [7:0]                    e1_r_ff,    e1_r_in;
   logic [7:0]                    e1_b_ff,    e1_b_in;
   logic [nus_pkg::YSUM_W-1:0]    e1_ysum_ff, e1_ysum_in;
   logic [7:0]                    g_exp;

   // Stage 2
   logic                          e2_vld_ff, e2_vld_in;
   logic [7:0]                    e2_r_ff,   e2_r_in;
   logic [7:0]                    e2_b_ff,   e2_b_in;
   logic [7:0]                    e2_y_ff,   e2_y_in;
   logic [nus_pkg::DIVP_W-1:0]    y_prod;

   // Stage 3
   logic                          e3_vld_ff,  e3_vld_in;
   logic [7:0]                    e3_y_ff,    e3_y_in;
   logic                          e3_uneg_ff, e3_uneg_in;
   logic                          e3_vneg_ff, e3_vneg_in;
   logic [nus_pkg::YSUM_W-1:0]    e3_umag_ff, e3_umag_in;
   logic [nus_pkg::YSUM_W-1:0]    e3_vmag_ff, e3_vmag_in;
   logic signed [8:0]             du, dv;
   logic [7:0]                    du_mag, dv_mag;

   // Stage 4
   logic                          e4_vld_ff, e4_vld_in;
   logic [nus_pkg::PIX_W-1:0]     e4_pix_ff, e4_pix_in;
   logic [nus_pkg::DIVP_W-1:0]    u_prod, v_prod;
   logic [7:0]                    uq, vq;
   logic signed [9:0]             u_val, v_val;
   logic [7:0]                    u_c, v_c;

   function automatic logic [7:0] clamp_byte(input logic signed [9:0] x);
      if (x < 10'sd0) begin
         return 8'd0;
      end else if (x > 10'sd255) begin
         return 8'hFF;
      end
      return x[7:0];
   endfunction

   // Stage 1: expand channels, weighted luma sum
   always_comb begin
      e1_vld_in  = in_vld;
      e1_r_in    = nus_pkg::EXP5_TBL[in_pixel[15:11]];
      g_exp      = nus_pkg::EXP6_TBL[in_pixel[10:5]];
      e1_b_in    = nus_pkg::EXP5_TBL[in_pixel[4:0]];
      e1_ysum_in = nus_pkg::YSUM_W'(e1_r_in) * nus_pkg::YSUM_W'(nus_pkg::Y_R)
                 + nus_pkg::YSUM_W'(g_exp)   * nus_pkg::YSUM_W'(nus_pkg::Y_G)
                 + nus_pkg::YSUM_W'(e1_b_in) * nus_pkg::YSUM_W'(nus_pkg::Y_B);
   end

   // Stage 2: luma = sum / 1000
   always_comb begin
      y_prod    = nus_pkg::DIVP_W'(e1_ysum_ff) * nus_pkg::DIVP_W'(nus_pkg::DIV_M);
      e2_vld_in = e1_vld_ff;
      e2_r_in   = e1_r_ff;
      e2_b_in   = e1_b_ff;
      e2_y_in   = 8'(y_prod >> nus_pkg::DIV_K);
   end

   // Stage 3: color differences as sign and scaled magnitude
   always_comb begin
      du         = $signed({1'b0, e2_b_ff}) - $signed({1'b0, e2_y_ff});
      dv         = $signed({1'b0, e2_r_ff}) - $signed({1'b0, e2_y_ff});
      du_mag     = du[8] ? 8'(-du) : du[7:0];
      dv_mag     = dv[8] ? 8'(-dv) : dv[7:0];
      e3_vld_in  = e2_vld_ff;
      e3_y_in    = e2_y_ff;
      e3_uneg_in = du[8];
      e3_vneg_in = dv[8];
      e3_umag_in = nus_pkg::YSUM_W'(du_mag) * nus_pkg::YSUM_W'(nus_pkg::U_K);
      e3_vmag_in = nus_pkg::YSUM_W'(dv_mag) * nus_pkg::YSUM_W'(nus_pkg::V_K);
   end

   // Stage 4: divide (truncating toward zero), offset, clamp, pack
   always_comb begin
      u_prod    = nus_pkg::DIVP_W'(e3_umag_ff) * nus_pkg::DIVP_W'(nus_pkg::DIV_M);
      v_prod    = nus_pkg::DIVP_W'(e3_vmag_ff) * nus_pkg::DIVP_W'(nus_pkg::DIV_M);
      uq        = 8'(u_prod >> nus_pkg::DIV_K);
      vq        = 8'(v_prod >> nus_pkg::DIV_K);
      u_val     = e3_uneg_ff
                ? $signed(10'(nus_pkg::CHROMA_OFS)) - $signed({2'b00, uq})
                : $signed(10'(nus_pkg::CHROMA_OFS)) + $signed({2'b00, uq});
      v_val     = e3_vneg_ff
                ? $signed(10'(nus_pkg::CHROMA_OFS)) - $signed({2'b00, vq})
                : $signed(10'(nus_pkg::CHROMA_OFS)) + $signed({2'b00, vq});
      u_c       = clamp_byte(u_val);
      v_c       = clamp_byte(v_val);
      e4_vld_in = e3_vld_ff;
      e4_pix_in = {v_c[7:3], e3_y_ff[7:2], u_c[7:3]};
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
         e2_vld_ff <= 1'b0;
         e3_vld_ff <= 1'b0;
         e4_vld_ff <= 1'b0;
      end else begin
         e1_vld_ff <= e1_vld_in;
         e2_vld_ff <= e2_vld_in;
         e3_vld_ff <= e3_vld_in;
         e4_vld_ff <= e4_vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      e1_r_ff    <= e1_r_in;
      e1_b_ff    <= e1_b_in;
      e1_ysum_ff <= e1_ysum_in;
      e2_r_ff    <= e2_r_in;
      e2_b_ff    <= e2_b_in;
      e2_y_ff    <= e2_y_in;
      e3_y_ff    <= e3_y_in;
      e3_uneg_ff <= e3_uneg_in;
      e3_vneg_ff <= e3_vneg_in;
      e3_umag_ff <= e3_umag_in;
      e3_vmag_ff <= e3_vmag_in;
      e4_pix_ff  <= e4_pix_in;
   end

   assign out_vld   = e4_vld_ff;
   assign out_pixel = e4_pix_ff;

endmodule

### hw/rtl/nus_outq.sv
// ----------------------------------------------------------------------------
// nus_outq: result queue with credit count
// Holds finished pixels until the response side takes them. Counts reads
// owed (in flight plus queued) so the queue can never overflow.
// ----------------------------------------------------------------------------
module nus_outq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take_read,
   input  logic                      push,
   input  logic [nus_pkg::PIX_W-1:0] push_data,
   input  logic                      out_ready,
   output logic                      out_valid,
   output logic [nus_pkg::PIX_W-1:0] out_data,
   output nus_pkg::q_stat_type       q_stat
);

   logic [nus_pkg::PIX_W-1:0]   slot_ff [nus_pkg::Q_DEPTH];
   logic [nus_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nus_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nus_pkg::Q_CNT_W-1:0] fill_ff,   fill_in;
   logic [nus_pkg::Q_CNT_W-1:0] owed_ff,   owed_in;
   logic                        pop;

   // Pointer and count updates
   always_comb begin
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + nus_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + nus_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + nus_pkg::Q_CNT_W'(push) - nus_pkg::Q_CNT_W'(pop);
      owed_in   = owed_ff + nus_pkg::Q_CNT_W'(take_read) - nus_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         owed_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         owed_ff   <= owed_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid       = (fill_ff != '0);
   assign out_data        = slot_ff[rd_ptr_ff];
   assign q_stat.can_take = (owed_ff < nus_pkg::Q_CNT_W'(nus_pkg::Q_DEPTH));
   assign q_stat.owed     = owed_ff;
   assign q_stat.fill     = fill_ff;

endmodule

### hw/rtl/nearest_upscale_rgb565_to_yuv565.sv
// ----------------------------------------------------------------------------
// nearest_upscale_rgb565_to_yuv565: nearest-neighbor scaler with YUV output
// Stores an RGB565 source frame; read requests map an output pixel to its
// nearest source pixel and return it converted to packed V5:Y6:U5.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, reads and writes mixed in any order;
//   the single frame store port takes one access per cycle in request order.
// A read passes address stages A-C, the frame store, converter and queue.
// Up to 16 reads may be owed at once; the request side stalls beyond that.
// Reset clears the pipeline and queue; frame contents stay undefined until
//   written, with no clearing pass.
module nearest_upscale_rgb565_to_yuv565 (
   input  logic       clock,
   input  logic       reset,
   nus_req_if.sink    req_chan,
   nus_rsp_if.source  rsp_chan
);

   logic                      accept;
   logic                      take_read;
   nus_pkg::mem_cmd_type      mem_cmd;
   logic                      rd_vld;
   logic [nus_pkg::PIX_W-1:0] rd_data;
   logic                      cvt_vld;
   logic [nus_pkg::PIX_W-1:0] cvt_pixel;
   nus_pkg::q_stat_type       q_stat;

   // Request transfer; no transfer while in reset
   assign req_chan.ready = q_stat.can_take && !reset;
   assign accept         = req_chan.valid && req_chan.ready;
   assign take_read      = accept && (req_chan.req_type == nus_pkg::REQ_READ);

   nus_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_chan.req_type),
      .src_col   (req_chan.src_col),
      .src_row   (req_chan.src_row),
      .src_pixel (req_chan.src_pixel),
      .out_col   (req_chan.out_col),
      .out_row   (req_chan.out_row),
      .mem_cmd   (mem_cmd)
   );

   nus_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .rd_vld  (rd_vld),
      .rd_data (rd_data)
   );

   nus_cvt u_cvt (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (rd_vld),
      .in_pixel  (rd_data),
      .out_vld   (cvt_vld),
      .out_pixel (cvt_pixel)
   );

   nus_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .take_read (take_read),
      .push      (cvt_vld),
      .push_data (cvt_pixel),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (rsp_chan.yuv_pixel),
      .q_stat    (q_stat)
   );

   // Every accepted read issues a frame store read after address stages A, B and C
   a_read_issues: assert property (@(posedge clock) disable iff (reset)
      take_read |-> ##3 mem_cmd.rd)
      else $error("accepted read did not reach the frame store");

   // Every frame store read yields a converted pixel through the converter stages
   a_read_converts: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.rd |-> ##5 cvt_vld)
      else $error("frame store read produced no converted pixel");

   // A converted pixel always finds room in the result queue
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      cvt_vld |-> (q_stat.fill < nus_pkg::Q_CNT_W'(nus_pkg::Q_DEPTH)))
      else $error("result queue full on push");

   // Owed reads never exceed the queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.owed <= nus_pkg::Q_CNT_W'(nus_pkg::Q_DEPTH))
      else $error("owed read count above queue depth");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: nearest_upscale_rgb565_to_yuv565 self-checking bench
// Writes source pixels and reads scaled output pixels over the valid/ready
// channels with random idles on both sides. Reads touch only written pixels;
// each is checked against a local scaler and color converter or a listed one.
// ----------------------------------------------------------------------------
module testbench;

   // Run sizing
   localparam int RANDOM_ITEMS = 1200;
   localparam int TAIL_CYCLES  = 30;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PRINT_CAP    = 40;

   // Packed results that can be read straight off the conversion formulas
   localparam logic [nus_pkg::PIX_W-1:0] YUV_BLACK = 16'h8010;
   localparam logic [nus_pkg::PIX_W-1:0] YUV_WHITE = 16'h87F0;

   // One request, with an optional hand-typed expected pixel for reads
   typedef struct packed {
      nus_pkg::req_kind_type           kind;
      logic [nus_pkg::SRC_COL_W-1:0]   src_col;
      logic [nus_pkg::SRC_ROW_W-1:0]   src_row;
      logic [nus_pkg::PIX_W-1:0]       src_pixel;
      logic [nus_pkg::OUT_COL_W-1:0]   out_col;
      logic [nus_pkg::OUT_ROW_W-1:0]   out_row;
      logic                            has_exp;
      logic [nus_pkg::PIX_W-1:0]       exp_yuv;
   } scaler_req_type;

   // Directed rows: corners, primaries, dropped writes, out-of-frame reads,
   // and a read right behind a write to the same pixel
   localparam int DIRECTED_N = 19;
   localparam scaler_req_type DIRECTED [DIRECTED_N] = '{
      '{nus_pkg::REQ_WRITE, 9'd0,   8'd0,   16'h0000, 10'd1023, 9'd511, 1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd319, 8'd199, 16'hFFFF, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd319, 8'd0,   16'hF800, 10'd512,  9'd256, 1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd0,   8'd199, 16'h07E0, 10'd1023, 9'd511, 1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd160, 8'd100, 16'h001F, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd100, 8'd50,  16'h8410, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd320, 8'd0,   16'h1234, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd511, 8'd255, 16'hAAAA, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd0,   8'd200, 16'h5555, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_READ,  9'd511, 8'd255, 16'hFFFF, 10'd0,    9'd0,   1'b1, YUV_BLACK},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd799,  9'd479, 1'b1, YUV_WHITE},
      '{nus_pkg::REQ_READ,  9'd511, 8'd255, 16'hFFFF, 10'd1023, 9'd511, 1'b1, YUV_WHITE},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd2,    9'd2,   1'b1, YUV_BLACK},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd1023, 9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd0,    9'd511, 1'b0, 16'h0},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd400,  9'd240, 1'b0, 16'h0},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd250,  9'd120, 1'b0, 16'h0},
      '{nus_pkg::REQ_WRITE, 9'd0,   8'd0,   16'hFFFF, 10'd0,    9'd0,   1'b0, 16'h0},
      '{nus_pkg::REQ_READ,  9'd0,   8'd0,   16'h0000, 10'd1,    9'd0,   1'b1, YUV_WHITE}
   };

   logic clock;
   logic reset;

   nus_req_if req_if ();
   nus_rsp_if rsp_if ();

   nearest_upscale_rgb565_to_yuv565 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Local copy of the frame and the pixels still owed by the block
   logic [nus_pkg::PIX_W-1:0] frame_copy [nus_pkg::FRAME_DEPTH];
   bit                        frame_written [nus_pkg::FRAME_DEPTH];
   int                        written_addrs [$];
   logic [nus_pkg::PIX_W-1:0] yuv_expected [$];
   logic [nus_pkg::PIX_W-1:0] yuv_want;

   int  errors;
   int  cycle_count;
   int  counted;
   int  writes_stored;
   int  writes_dropped;
   int  reads_sent;
   int  reads_off_frame;
   int  pixels_checked;
   bit  burst;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("nearest_upscale_rgb565_to_yuv565 verification failed");
      $finish;
   end

   // One line per mismatch, capped so a broken build cannot flood the log
   task automatic report_mismatch(input string msg);
      if (errors < PRINT_CAP) begin
         $display("MISMATCH @%0d: %s", cycle_count, msg);
      end
      errors++;
   endtask

   function automatic int clamp_byte(input int x);
      if (x < 0) return 0;
      if (x > nus_pkg::C8_MAX) return nus_pkg::C8_MAX;
      return x;
   endfunction

   // RGB565 to packed V5:Y6:U5, integer math truncating toward zero
   function automatic logic [nus_pkg::PIX_W-1:0] rgb565_to_yuv(
      input logic [nus_pkg::PIX_W-1:0] p);
      int r, g, b, y, u, v;
      r = int'(p[15:11]) * nus_pkg::C8_MAX / nus_pkg::C5_MAX;
      g = int'(p[10:5]) * nus_pkg::C8_MAX / nus_pkg::C6_MAX;
      b = int'(p[4:0]) * nus_pkg::C8_MAX / nus_pkg::C5_MAX;
      y = (nus_pkg::Y_R * r + nus_pkg::Y_G * g + nus_pkg::Y_B * b) / nus_pkg::YUV_DIV;
      u = ((b - y) * nus_pkg::U_K) / nus_pkg::YUV_DIV + nus_pkg::CHROMA_OFS;
      v = ((r - y) * nus_pkg::V_K) / nus_pkg::YUV_DIV + nus_pkg::CHROMA_OFS;
      y = clamp_byte(y);
      u = clamp_byte(u);
      v = clamp_byte(v);
      return {v[7:3], y[7:2], u[7:3]};
   endfunction

   // Output position to frame address, nearest neighbor, saturating
   function automatic int source_addr_of(input int dx, input int dy);
      int sx, sy;
      sx = dx * nus_pkg::SRC_W / nus_pkg::DST_W;
      sy = dy * nus_pkg::SRC_H / nus_pkg::DST_H;
      if (sx > nus_pkg::SRC_W - 1) sx = nus_pkg::SRC_W - 1;
      if (sy > nus_pkg::SRC_H - 1) sy = nus_pkg::SRC_H - 1;
      return sy * nus_pkg::SRC_W + sx;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Random RGB565, sometimes with channels pinned at zero or full scale
   function automatic logic [nus_pkg::PIX_W-1:0] rand_rgb565();
      logic [nus_pkg::PIX_W-1:0] p;
      p = nus_pkg::PIX_W'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 2))
            0: p[15:11] = 5'h00;
            1: p[15:11] = 5'h1F;
            default: ;
         endcase
         case ($urandom_range(0, 2))
            0: p[10:5] = 6'h00;
            1: p[10:5] = 6'h3F;
            default: ;
         endcase
         case ($urandom_range(0, 2))
            0: p[4:0] = 5'h00;
            1: p[4:0] = 5'h1F;
            default: ;
         endcase
      end
      return p;
   endfunction

   function automatic scaler_req_type make_write(input int col, input int row);
      scaler_req_type it;
      it.kind      = nus_pkg::REQ_WRITE;
      it.src_col   = nus_pkg::SRC_COL_W'(col);
      it.src_row   = nus_pkg::SRC_ROW_W'(row);
      it.src_pixel = rand_rgb565();
      it.out_col   = nus_pkg::OUT_COL_W'($urandom);
      it.out_row   = nus_pkg::OUT_ROW_W'($urandom);
      it.has_exp   = 1'b0;
      it.exp_yuv   = '0;
      return it;
   endfunction

   // Drive one request at the falling edge, hold it until the transfer,
   // then update the local frame and the owed pixels
   task automatic send_req(input scaler_req_type it);
      int addr;
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.req_type  <= it.kind;
      req_if.src_col   <= it.src_col;
      req_if.src_row   <= it.src_row;
      req_if.src_pixel <= it.src_pixel;
      req_if.out_col   <= it.out_col;
      req_if.out_row   <= it.out_row;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (it.kind)
         nus_pkg::REQ_WRITE: begin
            if (it.src_col < nus_pkg::SRC_W && it.src_row < nus_pkg::SRC_H) begin
               addr = int'(it.src_row) * nus_pkg::SRC_W + int'(it.src_col);
               frame_copy[addr] = it.src_pixel;
               if (!frame_written[addr]) written_addrs.push_back(addr);
               frame_written[addr] = 1'b1;
               writes_stored++;
            end else begin
               writes_dropped++;
            end
         end
         nus_pkg::REQ_READ: begin
            addr = source_addr_of(int'(it.out_col), int'(it.out_row));
            if (it.has_exp) yuv_expected.push_back(it.exp_yuv);
            else yuv_expected.push_back(rgb565_to_yuv(frame_copy[addr]));
            if (it.out_col >= nus_pkg::DST_W || it.out_row >= nus_pkg::DST_H)
               reads_off_frame++;
            reads_sent++;
         end
         default: ;
      endcase
   endtask

   // Optional idle, then the request
   task automatic issue(input scaler_req_type it);
      int gap;
      gap = burst ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      send_req(it);
   endtask

   // Read one output pixel; fill its source pixel first if never written
   task automatic issue_read(input int dx, input int dy);
      scaler_req_type it;
      int addr;
      addr = source_addr_of(dx, dy);
      if (!frame_written[addr]) begin
         issue(make_write(addr % nus_pkg::SRC_W, addr / nus_pkg::SRC_W));
         counted++;
      end
      it.kind      = nus_pkg::REQ_READ;
      it.src_col   = nus_pkg::SRC_COL_W'($urandom);
      it.src_row   = nus_pkg::SRC_ROW_W'($urandom);
      it.src_pixel = nus_pkg::PIX_W'($urandom);
      it.out_col   = nus_pkg::OUT_COL_W'(dx);
      it.out_row   = nus_pkg::OUT_ROW_W'(dy);
      it.has_exp   = 1'b0;
      it.exp_yuv   = '0;
      issue(it);
      counted++;
   endtask

   // Response side: runs of ready, then stalls; now and then a long clean run
   initial begin : rsp_stall
      int hi, lo;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         hi = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, 24);
         lo = pick_gap();
         repeat (hi) begin
            @(negedge clock);
            rsp_if.ready <= 1'b1;
         end
         repeat (lo) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
      end
   end

   // Check each response transfer against the oldest owed pixel
   always @(posedge clock) begin : rsp_check
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (yuv_expected.size() == 0) begin
            report_mismatch($sformatf("pixel 0x%04h with no read outstanding",
                                      rsp_if.yuv_pixel));
         end else begin
            yuv_want = yuv_expected.pop_front();
            if (rsp_if.yuv_pixel !== yuv_want) begin
               report_mismatch($sformatf("yuv_pixel 0x%04h, wanted 0x%04h",
                                         rsp_if.yuv_pixel, yuv_want));
            end
            pixels_checked++;
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      scaler_req_type it;
      int pick, run, dx0, dy0, addr, sx, sy, lo, hi;
      bit drained;
      errors          = 0;
      counted         = 0;
      writes_stored   = 0;
      writes_dropped  = 0;
      reads_sent      = 0;
      reads_off_frame = 0;
      pixels_checked  = 0;
      burst           = 1'b0;
      drained         = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = nus_pkg::REQ_WRITE;
      req_if.src_col   = '0;
      req_if.src_row   = '0;
      req_if.src_pixel = '0;
      req_if.out_col   = '0;
      req_if.out_row   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows
      foreach (DIRECTED[i]) issue(DIRECTED[i]);

      // Random traffic
      while (counted < RANDOM_ITEMS) begin
         // hold the sender once until every read has been answered
         if (!drained && counted >= RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            while (yuv_expected.size() != 0) @(posedge clock);
            drained = 1'b1;
         end
         if ($urandom_range(0, 29) == 0) burst = ~burst;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // off-frame write, must be dropped
            if ($urandom_range(0, 1) == 0)
               it = make_write($urandom_range(nus_pkg::SRC_W, 511),
                               $urandom_range(0, 255));
            else
               it = make_write($urandom_range(0, 511),
                               $urandom_range(nus_pkg::SRC_H, 255));
            issue(it);
         end else if (pick < 40) begin
            issue(make_write($urandom_range(0, nus_pkg::SRC_W - 1),
                             $urandom_range(0, nus_pkg::SRC_H - 1)));
            counted++;
         end else if (pick < 50) begin
            // scanline: a run of consecutive output pixels on one row
            run = $urandom_range(4, 32);
            dx0 = $urandom_range(0, 1023);
            dy0 = ($urandom_range(0, 9) == 0)
                ? $urandom_range(nus_pkg::DST_H, 511)
                : $urandom_range(0, nus_pkg::DST_H - 1);
            for (int i = 0; i < run; i++) issue_read((dx0 + i) % 1024, dy0);
         end else if (pick < 75 && written_addrs.size() != 0) begin
            // read back a pixel written earlier, any output position over it
            addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            sx = addr % nus_pkg::SRC_W;
            sy = addr / nus_pkg::SRC_W;
            lo = (sx * nus_pkg::DST_W + nus_pkg::SRC_W - 1) / nus_pkg::SRC_W;
            hi = ((sx + 1) * nus_pkg::DST_W + nus_pkg::SRC_W - 1) / nus_pkg::SRC_W - 1;
            dx0 = $urandom_range(lo, hi);
            lo = (sy * nus_pkg::DST_H + nus_pkg::SRC_H - 1) / nus_pkg::SRC_H;
            hi = ((sy + 1) * nus_pkg::DST_H + nus_pkg::SRC_H - 1) / nus_pkg::SRC_H - 1;
            dy0 = $urandom_range(lo, hi);
            issue_read(dx0, dy0);
         end else begin
            dx0 = ($urandom_range(0, 6) == 0)
                ? $urandom_range(nus_pkg::DST_W, 1023)
                : $urandom_range(0, nus_pkg::DST_W - 1);
            dy0 = ($urandom_range(0, 6) == 0)
                ? $urandom_range(nus_pkg::DST_H, 511)
                : $urandom_range(0, nus_pkg::DST_H - 1);
            issue_read(dx0, dy0);
         end
      end
      @(negedge clock);
      req_if.valid <= 1'b0;

      // Drain, then let the pipeline settle
      while (yuv_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (yuv_expected.size() != 0) begin
         report_mismatch($sformatf("%0d pixels never returned", yuv_expected.size()));
      end

      $display("Covered %0d stored and %0d dropped writes, %0d reads (%0d off-frame).",
               writes_stored, writes_dropped, reads_sent, reads_off_frame);
      $display("Compared %0d output pixels in %0d cycles; %0d mismatches.",
               pixels_checked, cycle_count, errors);
      if (errors == 0) begin
         $display("nearest_upscale_rgb565_to_yuv565 verification clean");
      end else begin
         $display("nearest_upscale_rgb565_to_yuv565 verification failed");
      end
      $finish;
   end

endmodule
